// ----- src/hrbp_pkg.sv -----
// Shared types, codes and constants for the HTTP request byte parser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hrbp_pkg;

   localparam int LENGTH_BITS_DEF = 32;
   localparam int NAME_LEN        = 14;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_EQUAL = 8'h3D;

   typedef enum logic [2:0] {
      ST_METHOD   = 3'd0,
      ST_URL      = 3'd1,
      ST_VERSION  = 3'd2,
      ST_FIELD    = 3'd3,
      ST_VALUE    = 3'd4,
      ST_FORM_KEY = 3'd5,
      ST_FORM_VAL = 3'd6,
      ST_DONE     = 3'd7
   } parse_state_type;

   typedef enum logic [1:0] {
      PH_LEAD   = 2'd0,
      PH_DIGITS = 2'd1,
      PH_STOP   = 2'd2
   } len_phase_type;

   typedef enum logic [2:0] {
      KIND_DELIM    = 3'd0,
      KIND_METHOD   = 3'd1,
      KIND_URL      = 3'd2,
      KIND_VERSION  = 3'd3,
      KIND_HDR_NAME = 3'd4,
      KIND_HDR_VAL  = 3'd5,
      KIND_FORM_KEY = 3'd6,
      KIND_FORM_VAL = 3'd7
   } byte_kind_type;

   typedef enum logic [1:0] {
      STAT_CONTINUE   = 2'd0,
      STAT_COMPLETE   = 2'd1,
      STAT_BAD_LENGTH = 2'd2,
      STAT_IGNORED    = 2'd3
   } parse_status_type;

   // Per-byte verdict handed from the parser to the result register.
   typedef struct packed {
      byte_kind_type    kind;
      logic             commit;
      parse_status_type status;
   } verdict_type;

   // Characters of the header name "Content-Length", by position.
   function automatic logic [7:0] name_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h43; // C
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h4C; // L
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- src/http_request_byte_parser.sv -----
// Top level of the HTTP request byte parser: input register, parser, result register.
// Depends on hrbp_pkg and instantiates hrbp_parser.
//
// This block takes an HTTP/1.1 request one byte per beat and returns one beat
// per input beat: the byte itself plus a tag saying whether it belongs to the
// method, URL, version, a header name or value, a urlencoded form key or value,
// or is a dropped delimiter. Headers named exactly "Content-Length" set the body
// length (decimal, leading blanks and one '+' allowed, last header wins,
// saturating at LENGTH_BITS); the body is counted down and every completed
// key/value pair is flagged. Status reports completion at the blank header line
// or the last body byte, a Content-Length with no digits as an error, and every
// later byte as ignored until a beat with the new-request flag restarts the
// parser. Throughput is one byte per clock while the result side does not stall.
// A byte accepted into the input register is parsed there, and its result beat
// is then loaded into the result register, where it is held until it is taken.
// The whole per-byte decision is combinational, between the two registers.
// Both registers advance together, so a stalled result side holds the input side
// after one more beat has been taken.
`default_nettype none

module http_request_byte_parser #(
   parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tuser,   // [0] new_request
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // [7:0] byte_value
   output logic      [5:0] rsp_tuser    // [2:0] byte_kind, [3] pair_commit, [5:4] parse_status
);

   // Input register stage.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_new_ff;

   // Result register stage.
   logic                  out_valid_ff;
   logic [7:0]            out_byte_ff;
   hrbp_pkg::verdict_type out_verdict_ff;

   hrbp_pkg::verdict_type verdict;
   logic                  advance;

   // The registered byte is parsed and moves to the result register whenever
   // the result register is empty or being drained in this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   hrbp_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .new_request (in_new_ff),
      .verdict     (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_new_ff  <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff    <= in_byte_ff;
         out_verdict_ff <= verdict;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_verdict_ff.status, out_verdict_ff.commit, out_verdict_ff.kind};

   a_in_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("registered input beat dropped without being parsed");

   a_out_held : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && !advance) |=> out_valid_ff)
      else $error("result beat lost while stalled");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      advance |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// ----- src/hrbp_length.sv -----
// Decimal Content-Length value reader with saturation.
// Depends on hrbp_pkg for the phase codes and character constants.
`default_nettype none

module hrbp_length #(
   parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic                   clear,
   input  wire logic                   add,
   input  wire logic [7:0]             data_byte,
   output logic       [LENGTH_BITS-1:0] accum,
   output logic                        valid
);

   hrbp_pkg::len_phase_type phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]  accum_ff, accum_in;
   logic                    valid_ff, valid_in;

   logic                    is_digit;
   logic                    is_lead_ws;
   logic [LENGTH_BITS+3:0]  times_ten;
   logic                    take_digit;

   assign is_digit   = (data_byte >= hrbp_pkg::CH_ZERO) && (data_byte <= hrbp_pkg::CH_NINE);
   assign is_lead_ws = (data_byte == hrbp_pkg::CH_SPACE) || (data_byte == hrbp_pkg::CH_TAB) ||
                       (data_byte == hrbp_pkg::CH_VT) || (data_byte == hrbp_pkg::CH_FF);

   // accum * 10 + digit; any carry above LENGTH_BITS means saturation.
   assign times_ten = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} +
                      {{LENGTH_BITS{1'b0}}, data_byte[3:0]};

   always_comb begin
      take_digit = 1'b0;
      phase_in   = phase_ff;
      case (phase_ff)
         hrbp_pkg::PH_LEAD: begin
            if (is_lead_ws) begin
               phase_in = hrbp_pkg::PH_LEAD;
            end else if (data_byte == hrbp_pkg::CH_PLUS) begin
               phase_in = hrbp_pkg::PH_DIGITS;
            end else if (is_digit) begin
               phase_in   = hrbp_pkg::PH_DIGITS;
               take_digit = 1'b1;
            end else begin
               phase_in = hrbp_pkg::PH_STOP;
            end
         end
         hrbp_pkg::PH_DIGITS: begin
            if (is_digit) begin
               take_digit = 1'b1;
            end else begin
               phase_in = hrbp_pkg::PH_STOP;
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   always_comb begin
      accum_in = accum_ff;
      valid_in = valid_ff;
      if (take_digit) begin
         valid_in = 1'b1;
         if (times_ten[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
            accum_in = {LENGTH_BITS{1'b1}};
         end else begin
            accum_in = times_ten[LENGTH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrbp_pkg::PH_LEAD;
         accum_ff <= '0;
         valid_ff <= 1'b0;
      end else if (step) begin
         if (clear) begin
            phase_ff <= hrbp_pkg::PH_LEAD;
            accum_ff <= '0;
            valid_ff <= 1'b0;
         end else if (add) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            valid_ff <= valid_in;
         end
      end
   end

   assign accum = accum_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

// ----- src/hrbp_parser.sv -----
// Request state machine: byte tagging, header name match and body countdown.
// Depends on hrbp_pkg and instantiates hrbp_length.
`default_nettype none

module hrbp_parser #(
   parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  new_request,
   output hrbp_pkg::verdict_type      verdict
);

   hrbp_pkg::parse_state_type state_ff, state_in, cur_state;
   logic [3:0]             pos_ff, pos_in;
   logic                   mis_ff, mis_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in, left_dec;

   logic                   len_clear, len_add, len_valid;
   logic [LENGTH_BITS-1:0] len_accum;

   logic is_ws, is_lf, is_cr, is_colon, is_amp, is_equal;
   logic name_full, left_nz, dec_zero, bad_length;

   assign is_lf    = data_byte == hrbp_pkg::CH_LF;
   assign is_cr    = data_byte == hrbp_pkg::CH_CR;
   assign is_colon = data_byte == hrbp_pkg::CH_COLON;
   assign is_amp   = data_byte == hrbp_pkg::CH_AMP;
   assign is_equal = data_byte == hrbp_pkg::CH_EQUAL;
   assign is_ws    = (data_byte == hrbp_pkg::CH_SPACE) || (data_byte == hrbp_pkg::CH_TAB) ||
                     is_lf || (data_byte == hrbp_pkg::CH_VT) ||
                     (data_byte == hrbp_pkg::CH_FF) || is_cr;

   // A new request restarts at the method whatever was left behind.
   assign cur_state  = new_request ? hrbp_pkg::ST_METHOD : state_ff;
   assign name_full  = (pos_ff == 4'(hrbp_pkg::NAME_LEN)) && !mis_ff;
   assign bad_length = name_full && !len_valid;
   assign left_nz    = left_ff != '0;
   assign left_dec   = left_nz ? left_ff - 1'b1 : left_ff;
   assign dec_zero   = left_dec == '0;

   hrbp_length #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_length (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .clear     (len_clear),
      .add       (len_add),
      .data_byte (data_byte),
      .accum     (len_accum),
      .valid     (len_valid)
   );

   // Next state.
   always_comb begin
      state_in = cur_state;
      unique case (cur_state)
         hrbp_pkg::ST_METHOD:  if (is_ws) state_in = hrbp_pkg::ST_URL;
         hrbp_pkg::ST_URL:     if (is_ws) state_in = hrbp_pkg::ST_VERSION;
         hrbp_pkg::ST_VERSION: if (is_lf) state_in = hrbp_pkg::ST_FIELD;
         hrbp_pkg::ST_FIELD: begin
            if (is_colon) begin
               state_in = hrbp_pkg::ST_VALUE;
            end else if (is_lf) begin
               state_in = left_nz ? hrbp_pkg::ST_FORM_KEY : hrbp_pkg::ST_DONE;
            end
         end
         hrbp_pkg::ST_VALUE: begin
            if (is_lf) begin
               state_in = bad_length ? hrbp_pkg::ST_DONE : hrbp_pkg::ST_FIELD;
            end
         end
         hrbp_pkg::ST_FORM_KEY: begin
            if (dec_zero) begin
               state_in = hrbp_pkg::ST_DONE;
            end else if (is_equal) begin
               state_in = hrbp_pkg::ST_FORM_VAL;
            end
         end
         hrbp_pkg::ST_FORM_VAL: begin
            if (dec_zero) begin
               state_in = hrbp_pkg::ST_DONE;
            end else if (is_amp) begin
               state_in = hrbp_pkg::ST_FORM_KEY;
            end
         end
         hrbp_pkg::ST_DONE:    state_in = hrbp_pkg::ST_DONE;
         default:              state_in = hrbp_pkg::ST_DONE;
      endcase
   end

   // Per-byte verdict.
   always_comb begin
      verdict.kind   = hrbp_pkg::KIND_DELIM;
      verdict.commit = 1'b0;
      verdict.status = hrbp_pkg::STAT_CONTINUE;
      unique case (cur_state)
         hrbp_pkg::ST_METHOD: if (!is_ws) verdict.kind = hrbp_pkg::KIND_METHOD;
         hrbp_pkg::ST_URL:    if (!is_ws) verdict.kind = hrbp_pkg::KIND_URL;
         hrbp_pkg::ST_VERSION: begin
            if (!is_lf && !is_cr) verdict.kind = hrbp_pkg::KIND_VERSION;
         end
         hrbp_pkg::ST_FIELD: begin
            if (is_lf) begin
               if (!left_nz) verdict.status = hrbp_pkg::STAT_COMPLETE;
            end else if (!is_colon && !is_cr) begin
               verdict.kind = hrbp_pkg::KIND_HDR_NAME;
            end
         end
         hrbp_pkg::ST_VALUE: begin
            if (is_lf) begin
               if (bad_length) verdict.status = hrbp_pkg::STAT_BAD_LENGTH;
            end else if (!is_cr) begin
               verdict.kind = hrbp_pkg::KIND_HDR_VAL;
            end
         end
         hrbp_pkg::ST_FORM_KEY: begin
            if (is_amp) begin
               verdict.commit = 1'b1;
            end else if (!is_equal) begin
               verdict.kind = hrbp_pkg::KIND_FORM_KEY;
            end
            if (dec_zero) begin
               verdict.commit = 1'b1;
               verdict.status = hrbp_pkg::STAT_COMPLETE;
            end
         end
         hrbp_pkg::ST_FORM_VAL: begin
            if (is_amp) begin
               verdict.commit = 1'b1;
            end else begin
               verdict.kind = hrbp_pkg::KIND_FORM_VAL;
            end
            if (dec_zero) begin
               verdict.commit = 1'b1;
               verdict.status = hrbp_pkg::STAT_COMPLETE;
            end
         end
         hrbp_pkg::ST_DONE: verdict.status = hrbp_pkg::STAT_IGNORED;
         default:           verdict.status = hrbp_pkg::STAT_IGNORED;
      endcase
   end

   // Name matcher, length reader control and body byte count.
   always_comb begin
      pos_in    = new_request ? 4'd0 : pos_ff;
      mis_in    = new_request ? 1'b0 : mis_ff;
      left_in   = new_request ? '0 : left_ff;
      len_clear = new_request;
      len_add   = 1'b0;
      case (cur_state)
         hrbp_pkg::ST_VERSION: begin
            if (is_lf) begin
               pos_in = 4'd0;
               mis_in = 1'b0;
            end
         end
         hrbp_pkg::ST_FIELD: begin
            if (is_colon) begin
               len_clear = 1'b1;
            end else if (!is_lf && !is_cr) begin
               if ((pos_ff < 4'(hrbp_pkg::NAME_LEN)) &&
                   (hrbp_pkg::name_char(pos_ff) == data_byte)) begin
                  pos_in = pos_ff + 4'd1;
               end else begin
                  mis_in = 1'b1;
               end
            end
         end
         hrbp_pkg::ST_VALUE: begin
            if (is_lf) begin
               if (!bad_length) begin
                  if (name_full) left_in = len_accum;
                  pos_in = 4'd0;
                  mis_in = 1'b0;
               end
            end else if (!is_cr) begin
               len_add = 1'b1;
            end
         end
         hrbp_pkg::ST_FORM_KEY: left_in = left_dec;
         hrbp_pkg::ST_FORM_VAL: left_in = left_dec;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrbp_pkg::ST_METHOD;
         pos_ff   <= 4'd0;
         mis_ff   <= 1'b0;
         left_ff  <= '0;
      end else if (step) begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         mis_ff   <= mis_in;
         left_ff  <= left_in;
      end
   end

   a_done_ignores : assert property (@(posedge clock) disable iff (reset)
      (step && !new_request && state_ff == hrbp_pkg::ST_DONE) |->
      (verdict.status == hrbp_pkg::STAT_IGNORED && verdict.kind == hrbp_pkg::KIND_DELIM &&
       !verdict.commit))
      else $error("byte after end of request was not ignored");

   a_commit_in_body : assert property (@(posedge clock) disable iff (reset)
      (step && verdict.commit) |->
      (cur_state == hrbp_pkg::ST_FORM_KEY || cur_state == hrbp_pkg::ST_FORM_VAL))
      else $error("pair commit outside the form body");

   a_end_goes_done : assert property (@(posedge clock) disable iff (reset)
      (step && (verdict.status == hrbp_pkg::STAT_COMPLETE ||
                verdict.status == hrbp_pkg::STAT_BAD_LENGTH)) |=>
      (state_ff == hrbp_pkg::ST_DONE))
      else $error("request ended but parser is not in done state");

   a_left_holds : assert property (@(posedge clock) disable iff (reset)
      (!step) |=> $stable(left_ff) && $stable(state_ff))
      else $error("parser state changed without a byte");

endmodule

`default_nettype wire
